// ----- src/uvst_pkg.sv -----
// ----------------------------------------------------------------------------
// Unique value set table package
// Shared sizes, request codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package uvst_pkg;

    // Table geometry.
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);

    // Stream field widths.
    localparam int OP_W       = 2;
    localparam int IN_IDX_W   = 4;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 48;

    // Request kinds.
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Control handed to every cell for one request.
    typedef struct packed {
        logic load;    // write the probe value into this cell
        logic remove;  // a remove request is being applied to the row
    } t_cell_ctl;

endpackage

// ----- src/unique_value_set_table.sv -----
// ----------------------------------------------------------------------------
// Unique value set table
// A bounded set of distinct values kept densely in insertion order.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: tuser carries the request kind
// (lookup, add, remove, read by index), tdata carries the value and index.
// Every request yields exactly one result transfer on the master stream
// with the found flag, the count after the request, the empty flag, the
// full rejection flag and, for reads, the entry and its valid bit.
// The entries sit in a row of cells that all compare against the request
// value at once; a remove shifts every cell above the match down one place
// in the same cycle. The result is registered, and one request is taken
// per cycle while the receiver does not stall. The result register is the
// only buffer: while the receiver stalls and a result is held, no new
// request is taken; it is taken in the same cycle that the held result is
// transferred. Reset empties the table (count zero) and clears the result
// valid flag; entries are only read below the count.
// ----------------------------------------------------------------------------
module unique_value_set_table
    import uvst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request stream.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // value[31:0], index[35:32], zero fill
    input  logic [OP_W-1:0]     s_axis_tuser,  // op[1:0]
    // Result stream.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata   // found[0], count[5:1], is_empty[6],
                                               // rejected_full[7], read_value[39:8],
                                               // read_valid[40], zero fill
);

    logic                  w_accept;
    t_op                   w_op;
    logic [VALUE_BITS-1:0] w_probe;
    logic [IN_IDX_W-1:0]   w_index;

    logic [CAPACITY-1:0]   w_match;
    logic [CAPACITY:0]     w_seen;
    logic [VALUE_BITS-1:0] w_value [CAPACITY];
    t_cell_ctl             w_ctl   [CAPACITY];

    logic                  w_found;
    logic                  w_full;
    logic                  w_do_add;
    logic                  w_do_remove;
    logic                  w_rd_valid;
    logic [VALUE_BITS-1:0] w_rd_value;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_m_valid;
    logic                  n_m_valid;
    logic [M_DATA_W-1:0]   r_m_data;
    logic [M_DATA_W-1:0]   n_m_data;

    // Handshake and field unpacking.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_probe       = s_axis_tdata[VALUE_BITS-1:0];
    assign w_index       = s_axis_tdata[32 +: IN_IDX_W];

    // Request decode against the current table.
    assign w_found     = (w_op != OP_READ) && (|w_match);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_do_add    = w_accept && (w_op == OP_ADD) && !(|w_match) && !w_full;
    assign w_do_remove = w_accept && (w_op == OP_REMOVE);
    assign w_rd_valid  = (w_op == OP_READ) && ({{(CNT_W-IN_IDX_W){1'b0}}, w_index} < r_count);
    assign w_rd_value  = w_rd_valid ? w_value[w_index[IDX_W-1:0]] : '0;

    // Row of cells; the gap marker ripples from the bottom cell upward.
    assign w_seen[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_next;

        if (g == CAPACITY - 1) begin : g_top
            assign w_next = w_value[g];
        end else begin : g_mid
            assign w_next = w_value[g+1];
        end

        assign w_ctl[g].load   = w_do_add && (r_count == CNT_W'(g));
        assign w_ctl[g].remove = w_do_remove;

        uvst_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[g]),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_probe      (w_probe),
            .i_next_value (w_next),
            .i_seen       (w_seen[g]),
            .o_seen       (w_seen[g+1]),
            .o_match      (w_match[g]),
            .o_value      (w_value[g])
        );
    end

    // Count and result register update.
    always_comb begin
        n_count   = r_count;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (w_do_add) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_remove && w_found) begin
            n_count = r_count - CNT_W'(1);
        end
        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        if (w_accept) begin
            n_m_valid = 1'b1;
            n_m_data  = '0;
            n_m_data[0]    = w_found;
            n_m_data[5:1]  = 5'(n_count);
            n_m_data[6]    = (n_count == '0);
            n_m_data[7]    = (w_op == OP_ADD) && !(|w_match) && w_full;
            n_m_data[39:8] = 32'(w_rd_value);
            n_m_data[40]   = w_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // The table never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    // Stored values are distinct, so at most one live cell matches.
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matches the probe");

    // An add of a new value with room left grows the count by one.
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_add |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("add did not grow the count");

    // A successful remove shrinks the count by one.
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_remove && w_found) |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("remove did not shrink the count");

    // A full rejection is only reported with a full table.
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[7]) |-> r_m_data[5:1] == 5'(CAPACITY))
        else $error("rejection reported below capacity");

endmodule

// ----- src/uvst_cell.sv -----
// ----------------------------------------------------------------------------
// Unique value set table cell
// Holds one entry, compares it against the probe and shifts in its upper
// neighbor's entry when a remove closes a gap at or below it.
// ----------------------------------------------------------------------------
module uvst_cell
    import uvst_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic                  i_occupied,
    input  logic [VALUE_BITS-1:0] i_probe,
    input  logic [VALUE_BITS-1:0] i_next_value,
    input  logic                  i_seen,
    output logic                  o_seen,
    output logic                  o_match,
    output logic [VALUE_BITS-1:0] o_value
);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    // A cell matches only while it holds a live entry.
    assign o_match = i_occupied && (r_value == i_probe);

    // A match here or in any lower cell marks this cell as part of the gap.
    assign o_seen  = i_seen || o_match;
    assign o_value = r_value;

    // Entry update: load on add, take the neighbor's entry on remove.
    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_probe;
        end else if (i_ctl.remove && o_seen) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
